FILE: sv/dsms_pkg.sv
// ----------------------------------------------------------------------------
// dsms_pkg
// Shared types and constants of the daily schedule motor sequencer.
// ----------------------------------------------------------------------------
package dsms_pkg;

  // Field and datapath widths
  localparam int TIME_W     = 17;
  localparam int MPD_W      = 16;
  localparam int CMD_W      = 2;
  localparam int DRV_W      = 2;
  localparam int SEQ_W      = 3;
  localparam int TIMER_W    = 32;
  localparam int PROD_W     = 2 * TIME_W;
  localparam int CNT_W      = $clog2(PROD_W + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TIME_W;

  // Register reset values
  localparam logic [TIME_W-1:0] START_RST = TIME_W'(32400);
  localparam logic [TIME_W-1:0] STOP_RST  = TIME_W'(64800);
  localparam logic [TIME_W-1:0] NIGHT_RST = TIME_W'(72000);
  localparam logic [TIME_W-1:0] MOVE_RST  = TIME_W'(330);
  localparam logic [MPD_W-1:0]  MPD_RST   = MPD_W'(30);

  // Item kind
  localparam logic MODE_TICK = 1'b0;

  typedef enum logic [SEQ_W-1:0] {
    ST_MANUAL       = 3'd0,
    ST_FIND_START   = 3'd1,
    ST_WAIT_MORNING = 3'd2,
    ST_MOVING       = 3'd3,
    ST_PAUSING      = 3'd4,
    ST_WAIT_NIGHT   = 3'd5
  } seq_state_e;

  typedef enum logic [DRV_W-1:0] {
    DRV_STOP    = 2'd0,
    DRV_FORWARD = 2'd1,
    DRV_BACK    = 2'd2
  } drive_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_STOP    = 2'd0,
    CMD_AUTO    = 2'd1,
    CMD_FORWARD = 2'd2,
    CMD_BACK    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START = 3'd0,
    CFG_STOP  = 3'd1,
    CFG_NIGHT = 3'd2,
    CFG_MOVE  = 3'd3,
    CFG_MPD   = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    C_IDLE,
    C_EVAL,
    C_PER_GO,
    C_PER_WAIT,
    C_SCL_GO,
    C_SCL_WAIT,
    C_ON_GO,
    C_ON_WAIT,
    C_DONE
  } ctrl_state_e;

  // Schedule registers as seen by the sequencer
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] stop_time;
    logic [TIME_W-1:0] night_time;
    logic [TIME_W-1:0] move_time;
    logic [MPD_W-1:0]  moves_per_day;
  } cfg_t;

  // Divider request
  typedef struct packed {
    logic              start;
    logic              wide;
    logic [PROD_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  // Divider response
  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: sv/dsms_if.sv
// ----------------------------------------------------------------------------
// dsms_in_if / dsms_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface dsms_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [dsms_pkg::CMD_W-1:0]  command;
  logic [dsms_pkg::TIME_W-1:0] now_sec;
  logic                        at_start;

  modport source (output valid, mode, command, now_sec, at_start, input ready);
  modport sink   (input valid, mode, command, now_sec, at_start, output ready);
endinterface

interface dsms_out_if;
  logic                       valid;
  logic                       ready;
  logic                       drive_valid;
  logic [dsms_pkg::DRV_W-1:0] drive_cmd;
  logic [dsms_pkg::SEQ_W-1:0] seq_state;

  modport source (output valid, drive_valid, drive_cmd, seq_state, input ready);
  modport sink   (input valid, drive_valid, drive_cmd, seq_state, output ready);
endinterface

FILE: sv/dsms_cfg.sv
// ----------------------------------------------------------------------------
// dsms_cfg
// Schedule register file; a zero moves-per-day field is stored as one.
// ----------------------------------------------------------------------------
module dsms_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dsms_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dsms_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output dsms_pkg::cfg_t                  cfg_o
);

  dsms_pkg::cfg_t              cfg_q, cfg_d;
  logic [dsms_pkg::MPD_W-1:0]  mpd_wr;

  // Clamp a zero move count to one
  assign mpd_wr = (cfg_data_i[dsms_pkg::MPD_W-1:0] == '0) ?
                  dsms_pkg::MPD_W'(1) : cfg_data_i[dsms_pkg::MPD_W-1:0];

  // Decode the register write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (dsms_pkg::cfg_idx_e'(cfg_idx_i))
        dsms_pkg::CFG_START: cfg_d.start_time    = cfg_data_i;
        dsms_pkg::CFG_STOP:  cfg_d.stop_time     = cfg_data_i;
        dsms_pkg::CFG_NIGHT: cfg_d.night_time    = cfg_data_i;
        dsms_pkg::CFG_MOVE:  cfg_d.move_time     = cfg_data_i;
        dsms_pkg::CFG_MPD:   cfg_d.moves_per_day = mpd_wr;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_time    <= dsms_pkg::START_RST;
      cfg_q.stop_time     <= dsms_pkg::STOP_RST;
      cfg_q.night_time    <= dsms_pkg::NIGHT_RST;
      cfg_q.move_time     <= dsms_pkg::MOVE_RST;
      cfg_q.moves_per_day <= dsms_pkg::MPD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/dsms_div.sv
// ----------------------------------------------------------------------------
// dsms_div
// Shared restoring divider, one quotient bit per cycle. A narrow request
// divides a TIME_W-bit dividend in TIME_W steps, a wide one a PROD_W-bit
// dividend in PROD_W steps. The quotient must fit in TIME_W bits.
// ----------------------------------------------------------------------------
module dsms_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dsms_pkg::div_req_t req_i,
  output dsms_pkg::div_rsp_t rsp_o
);

  localparam int TW = dsms_pkg::TIME_W;
  localparam int PW = dsms_pkg::PROD_W;
  localparam int CW = dsms_pkg::CNT_W;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [TW-1:0] rem_q, rem_d;
  logic [PW-1:0] quo_q, quo_d;
  logic [TW-1:0] div_q;
  logic [TW:0]   trial;
  logic [TW+1:0] diff;
  logic          ge;

  // One restoring step
  assign trial = {rem_q, quo_q[PW-1]};
  assign diff  = {1'b0, trial} - {2'b00, div_q};
  assign ge    = ~diff[TW+1];

  // Load on request, otherwise iterate while busy
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      rem_d  = '0;
      if (req_i.wide) begin
        quo_d = req_i.dividend;
        cnt_d = CW'(PW);
      end else begin
        quo_d = {req_i.dividend[TW-1:0], {(PW-TW){1'b0}}};
        cnt_d = CW'(TW);
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[TW-1:0] : trial[TW-1:0];
      quo_d = {quo_q[PW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      div_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q[TW-1:0];

endmodule

FILE: sv/daily_schedule_motor_sequencer_core.sv
// Flow: an accepted input beat is evaluated in C_EVAL, runs the divisions it needs
// (new move period, new on time or both; the on time scaled for a mid-span start) and
// is then registered in the output register once that is empty or being taken.
// Throughput: one beat at a time; the next input beat is taken only after the last
// result is loaded, so it waits on the shared bit-serial divider and output stalls.
// Reset: asynchronous; clears sequence, timers and output valid, loads schedule.
// ----------------------------------------------------------------------------
// daily_schedule_motor_sequencer_core
// Tick/command driven daily motor sequencer with one shared divider.
// ----------------------------------------------------------------------------
module daily_schedule_motor_sequencer_core #(
  parameter int TICKS_PER_SECOND = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dsms_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dsms_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dsms_in_if.sink                         in_i,
  dsms_out_if.source                      out_o
);

  localparam int TW    = dsms_pkg::TIME_W;
  localparam int PW    = dsms_pkg::PROD_W;
  localparam int TMW   = dsms_pkg::TIMER_W;
  localparam int PRE_W = $clog2(TICKS_PER_SECOND + 1);

  dsms_pkg::cfg_t        cfg;
  dsms_pkg::div_req_t    div_req;
  dsms_pkg::div_rsp_t    div_rsp;
  dsms_pkg::ctrl_state_e ctrl_q, ctrl_d;

  // Item registers
  logic                       item_mode_q;
  logic [dsms_pkg::CMD_W-1:0] item_cmd_q;
  logic [TW-1:0]              item_now_q;
  logic                       item_at_start_q;

  // Sequence state
  dsms_pkg::seq_state_e seq_q;
  logic [PRE_W-1:0]     pre_q;
  logic [TMW-1:0]       timer_q;
  logic [TW-1:0]        period_mag_q;
  logic                 period_neg_q;
  logic [TW-1:0]        on_time_q;
  logic [PW-1:0]        prod_q;
  logic                 span_neg_q;
  logic [TW-1:0]        span_mag_q;
  logic                 need_scl_q, need_on_q;

  // Pending and output result
  logic                 res_dv_q;
  dsms_pkg::drive_e     res_dc_q;
  logic                 out_valid_q;
  logic                 out_dv_q;
  dsms_pkg::drive_e     out_dc_q;
  dsms_pkg::seq_state_e out_seq_q;
  logic                 out_load;

  // Evaluation results
  logic [PRE_W-1:0]     pre_inc, pre_n;
  logic                 sec_wrap;
  logic [TMW-1:0]       timer_n;
  logic                 span_neg;
  logic [TW-1:0]        span_mag;
  logic [TW-1:0]        pos;
  dsms_pkg::seq_state_e ev_seq;
  logic                 ev_dv;
  dsms_pkg::drive_e     ev_dc;
  logic                 ev_clr, ev_per, ev_scl, ev_on, ev_zero_on;

  dsms_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dsms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Advance prescaler and seconds timer
  assign pre_inc  = pre_q + 1'b1;
  assign sec_wrap = (pre_inc >= PRE_W'(TICKS_PER_SECOND));
  assign pre_n    = sec_wrap ? '0 : pre_inc;
  assign timer_n  = sec_wrap ? timer_q + 1'b1 : timer_q;

  // Span magnitude and sign, offset into the span
  assign span_neg = (cfg.stop_time < cfg.start_time);
  assign span_mag = span_neg ? cfg.start_time - cfg.stop_time
                             : cfg.stop_time - cfg.start_time;
  assign pos      = item_now_q - cfg.start_time;

  // Decide the sequence step for the held item
  always_comb begin
    ev_seq     = seq_q;
    ev_dv      = 1'b0;
    ev_dc      = dsms_pkg::DRV_STOP;
    ev_clr     = 1'b0;
    ev_per     = 1'b0;
    ev_scl     = 1'b0;
    ev_on      = 1'b0;
    ev_zero_on = 1'b0;
    if (item_mode_q != dsms_pkg::MODE_TICK) begin
      ev_dv = 1'b1;
      unique case (dsms_pkg::cmd_e'(item_cmd_q))
        dsms_pkg::CMD_STOP: begin
          ev_seq = dsms_pkg::ST_MANUAL;
          ev_dc  = dsms_pkg::DRV_STOP;
        end
        dsms_pkg::CMD_AUTO: begin
          ev_seq = dsms_pkg::ST_FIND_START;
          ev_dc  = dsms_pkg::DRV_BACK;
        end
        dsms_pkg::CMD_FORWARD: begin
          ev_seq = dsms_pkg::ST_MANUAL;
          ev_dc  = dsms_pkg::DRV_FORWARD;
        end
        dsms_pkg::CMD_BACK: begin
          ev_seq = dsms_pkg::ST_MANUAL;
          ev_dc  = dsms_pkg::DRV_BACK;
        end
      endcase
    end else begin
      case (seq_q)
        dsms_pkg::ST_FIND_START: begin
          if (!item_at_start_q) begin
            ev_dv = 1'b1;
            if (item_now_q >= cfg.start_time && cfg.stop_time >= item_now_q) begin
              ev_per     = 1'b1;
              ev_zero_on = (span_mag == '0);
              ev_scl     = (span_mag != '0);
              ev_clr     = 1'b1;
              ev_dc      = dsms_pkg::DRV_FORWARD;
              ev_seq     = dsms_pkg::ST_MOVING;
            end else begin
              ev_dc  = dsms_pkg::DRV_STOP;
              ev_seq = dsms_pkg::ST_WAIT_MORNING;
            end
          end
        end
        dsms_pkg::ST_WAIT_MORNING: begin
          if (item_now_q == cfg.start_time) begin
            ev_per = 1'b1;
            ev_on  = 1'b1;
            ev_clr = 1'b1;
            ev_dv  = 1'b1;
            ev_dc  = dsms_pkg::DRV_FORWARD;
            ev_seq = dsms_pkg::ST_MOVING;
          end
        end
        dsms_pkg::ST_MOVING: begin
          if (item_now_q >= cfg.stop_time) begin
            ev_dv  = 1'b1;
            ev_dc  = dsms_pkg::DRV_STOP;
            ev_seq = dsms_pkg::ST_WAIT_NIGHT;
          end else if (timer_n > TMW'(on_time_q)) begin
            ev_dv  = 1'b1;
            ev_dc  = dsms_pkg::DRV_STOP;
            ev_seq = dsms_pkg::ST_PAUSING;
          end
        end
        dsms_pkg::ST_PAUSING: begin
          if (item_now_q >= cfg.stop_time) begin
            ev_seq = dsms_pkg::ST_WAIT_NIGHT;
          end else if (!period_neg_q && timer_n >= TMW'(period_mag_q)) begin
            ev_clr = 1'b1;
            ev_on  = 1'b1;
            ev_dv  = 1'b1;
            ev_dc  = dsms_pkg::DRV_FORWARD;
            ev_seq = dsms_pkg::ST_MOVING;
          end
        end
        dsms_pkg::ST_WAIT_NIGHT: begin
          if (item_now_q >= cfg.night_time) begin
            ev_dv  = 1'b1;
            ev_dc  = dsms_pkg::DRV_BACK;
            ev_seq = dsms_pkg::ST_FIND_START;
          end
        end
        default: begin
          ev_seq = seq_q;
        end
      endcase
    end
  end

  // Load the output register in C_DONE when it is empty or being taken
  assign out_load = (ctrl_q == dsms_pkg::C_DONE) && (!out_valid_q || out_o.ready);

  // Sequencer next state
  always_comb begin
    ctrl_d = ctrl_q;
    unique case (ctrl_q)
      dsms_pkg::C_IDLE: begin
        if (in_i.valid) ctrl_d = dsms_pkg::C_EVAL;
      end
      dsms_pkg::C_EVAL: begin
        priority if (ev_per) ctrl_d = dsms_pkg::C_PER_GO;
        else if (ev_on)      ctrl_d = dsms_pkg::C_ON_GO;
        else                 ctrl_d = dsms_pkg::C_DONE;
      end
      dsms_pkg::C_PER_GO:  ctrl_d = dsms_pkg::C_PER_WAIT;
      dsms_pkg::C_PER_WAIT: begin
        if (div_rsp.done) begin
          priority if (need_scl_q) ctrl_d = dsms_pkg::C_SCL_GO;
          else if (need_on_q)      ctrl_d = dsms_pkg::C_ON_GO;
          else                     ctrl_d = dsms_pkg::C_DONE;
        end
      end
      dsms_pkg::C_SCL_GO:  ctrl_d = dsms_pkg::C_SCL_WAIT;
      dsms_pkg::C_SCL_WAIT: begin
        if (div_rsp.done) ctrl_d = dsms_pkg::C_DONE;
      end
      dsms_pkg::C_ON_GO:   ctrl_d = dsms_pkg::C_ON_WAIT;
      dsms_pkg::C_ON_WAIT: begin
        if (div_rsp.done) ctrl_d = dsms_pkg::C_DONE;
      end
      dsms_pkg::C_DONE: begin
        if (out_load) ctrl_d = dsms_pkg::C_IDLE;
      end
      default: ctrl_d = dsms_pkg::C_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and divider operand select
  always_comb begin
    in_i.ready       = 1'b0;
    div_req.start    = 1'b0;
    div_req.wide     = 1'b0;
    div_req.dividend = PW'(span_mag_q);
    div_req.divisor  = TW'(cfg.moves_per_day);
    unique case (ctrl_q)
      dsms_pkg::C_IDLE:   in_i.ready = 1'b1;
      dsms_pkg::C_PER_GO: div_req.start = 1'b1;
      dsms_pkg::C_SCL_GO: begin
        div_req.start    = 1'b1;
        div_req.wide     = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = span_mag_q;
      end
      dsms_pkg::C_ON_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = PW'(cfg.move_time);
      end
      default: div_req.start = 1'b0;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q       <= dsms_pkg::C_IDLE;
      seq_q        <= dsms_pkg::ST_MANUAL;
      pre_q        <= '0;
      timer_q      <= '0;
      period_mag_q <= '0;
      period_neg_q <= 1'b0;
      on_time_q    <= '0;
      need_scl_q   <= 1'b0;
      need_on_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      ctrl_q <= ctrl_d;
      // Commit the step of the held item
      if (ctrl_q == dsms_pkg::C_EVAL) begin
        seq_q      <= ev_seq;
        need_scl_q <= ev_scl;
        need_on_q  <= ev_on;
        if (item_mode_q == dsms_pkg::MODE_TICK) begin
          pre_q   <= pre_n;
          timer_q <= ev_clr ? '0 : timer_n;
        end
        if (ev_zero_on) on_time_q <= '0;
      end
      // Capture division results
      if (div_rsp.done) begin
        if (ctrl_q == dsms_pkg::C_PER_WAIT) begin
          period_mag_q <= div_rsp.quotient;
          period_neg_q <= span_neg_q && (div_rsp.quotient != '0);
        end else if (ctrl_q == dsms_pkg::C_SCL_WAIT || ctrl_q == dsms_pkg::C_ON_WAIT) begin
          on_time_q <= div_rsp.quotient;
        end
      end
      // Output beat valid
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_mode_q     <= in_i.mode;
      item_cmd_q      <= in_i.command;
      item_now_q      <= in_i.now_sec;
      item_at_start_q <= in_i.at_start;
    end
    if (ctrl_q == dsms_pkg::C_EVAL) begin
      res_dv_q   <= ev_dv;
      res_dc_q   <= ev_dc;
      span_neg_q <= span_neg;
      span_mag_q <= span_mag;
      prod_q     <= PW'(pos) * PW'(cfg.move_time);
    end
    if (out_load) begin
      out_dv_q  <= res_dv_q;
      out_dc_q  <= res_dc_q;
      out_seq_q <= seq_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drive_valid = out_dv_q;
  assign out_o.drive_cmd   = out_dc_q;
  assign out_o.seq_state   = out_seq_q;

endmodule

FILE: tb/sv/tb_daily_schedule_motor_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_daily_schedule_motor_sequencer_core
// Self-checking bench for the daily motor sequencer. The bench holds its own
// copy of the schedule and the sequence, predicts one drive/state beat per
// accepted tick or command, and compares each output beat with the oldest
// prediction. It starts with a directed pass and a few edge schedules, then
// runs random compressed days under random schedules.
// ----------------------------------------------------------------------------
module tb_daily_schedule_motor_sequencer_core;
  import dsms_pkg::*;

  localparam int TICKS_PER_SEC = 10;
  localparam int RUN_LIMIT     = 400000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int IDLE_PCT      = 12;
  localparam int RANDOM_BEATS  = 300;
  localparam int HOLD_AT_BEAT  = 120;
  localparam int HOLD_CYCLES   = 300;
  localparam int CALM_FROM     = 250;
  localparam int CALM_TO       = 350;
  localparam int MAX_REPORTS   = 10;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [TIME_W-1:0] DAY_LAST = TIME_W'(86399);
  localparam logic MODE_CMD = 1'b1;

  typedef struct packed {
    logic              mode;
    cmd_e              command;
    logic [TIME_W-1:0] now_sec;
    logic              at_start;
  } beat_t;

  typedef struct packed {
    logic       drive_valid;
    drive_e     drive_cmd;
    seq_state_e seq_state;
  } motor_out_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dsms_in_if  in_if ();
  dsms_out_if out_if ();

  daily_schedule_motor_sequencer_core #(
    .TICKS_PER_SECOND(TICKS_PER_SEC)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // Shadow schedule and sequencer state
  cfg_t                     sched;
  seq_state_e               seq_q;
  logic [3:0]               presc_q;
  logic [TIMER_W-1:0]       secs_q;
  logic signed [TIME_W:0]   period_q;
  logic [TIME_W:0]          on_secs_q;

  beat_t      pending_q[$];
  motor_out_t motor_exp_q[$];
  beat_t      beat_on_bus;
  logic       bus_busy;
  int         beats_queued;
  int         beats_sent;
  int         results_seen;
  int         mismatches;
  int         hold_left = 0;
  logic       hold_done = 1'b0;

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Move period: signed span over moves per day, truncated toward zero
  function automatic logic signed [TIME_W:0] span_period();
    int span;
    span = int'(sched.stop_time) - int'(sched.start_time);
    return span / int'(sched.moves_per_day);
  endfunction

  function automatic logic [TIME_W:0] daily_on_secs();
    return sched.move_time / sched.moves_per_day;
  endfunction

  // Advance the shadow sequencer by one beat and return its output
  function automatic motor_out_t predict_beat(beat_t b);
    motor_out_t r;
    longint     span_len;
    longint     pos;
    r.drive_valid = 1'b0;
    r.drive_cmd   = DRV_STOP;
    if (b.mode == MODE_CMD) begin
      r.drive_valid = 1'b1;
      case (b.command)
        CMD_STOP: begin
          seq_q       = ST_MANUAL;
          r.drive_cmd = DRV_STOP;
        end
        CMD_AUTO: begin
          seq_q       = ST_FIND_START;
          r.drive_cmd = DRV_BACK;
        end
        CMD_FORWARD: begin
          seq_q       = ST_MANUAL;
          r.drive_cmd = DRV_FORWARD;
        end
        default: begin
          seq_q       = ST_MANUAL;
          r.drive_cmd = DRV_BACK;
        end
      endcase
    end else begin
      presc_q = presc_q + 4'd1;
      if (presc_q >= TICKS_PER_SEC) begin
        presc_q = '0;
        secs_q  = secs_q + 1;
      end
      case (seq_q)
        ST_FIND_START: begin
          if (!b.at_start) begin
            r.drive_valid = 1'b1;
            if (b.now_sec >= sched.start_time && sched.stop_time >= b.now_sec) begin
              // mid-span entry: scale on time to the elapsed part of the span
              span_len    = longint'(sched.stop_time - sched.start_time);
              pos         = longint'(b.now_sec - sched.start_time);
              period_q    = span_period();
              on_secs_q   = (span_len == 0) ? '0
                          : (TIME_W+1)'((pos * longint'(sched.move_time)) / span_len);
              secs_q      = '0;
              r.drive_cmd = DRV_FORWARD;
              seq_q       = ST_MOVING;
            end else begin
              r.drive_cmd = DRV_STOP;
              seq_q       = ST_WAIT_MORNING;
            end
          end
        end
        ST_WAIT_MORNING: begin
          if (b.now_sec == sched.start_time) begin
            period_q      = span_period();
            on_secs_q     = daily_on_secs();
            secs_q        = '0;
            r.drive_valid = 1'b1;
            r.drive_cmd   = DRV_FORWARD;
            seq_q         = ST_MOVING;
          end
        end
        ST_MOVING: begin
          if (b.now_sec >= sched.stop_time) begin
            r.drive_valid = 1'b1;
            seq_q         = ST_WAIT_NIGHT;
          end else if (secs_q > on_secs_q) begin
            r.drive_valid = 1'b1;
            seq_q         = ST_PAUSING;
          end
        end
        ST_PAUSING: begin
          if (b.now_sec >= sched.stop_time) begin
            seq_q = ST_WAIT_NIGHT;
          end else if (period_q >= 0 && secs_q >= $unsigned(period_q)) begin
            secs_q        = '0;
            on_secs_q     = daily_on_secs();
            r.drive_valid = 1'b1;
            r.drive_cmd   = DRV_FORWARD;
            seq_q         = ST_MOVING;
          end
        end
        ST_WAIT_NIGHT: begin
          if (b.now_sec >= sched.night_time) begin
            r.drive_valid = 1'b1;
            r.drive_cmd   = DRV_BACK;
            seq_q         = ST_FIND_START;
          end
        end
        default: ;
      endcase
    end
    r.seq_state = seq_q;
    return r;
  endfunction

  // Queue one tick beat; the command field is don't-care and randomized
  function automatic void add_tick(int now, logic at_start);
    pending_q.push_back('{mode: MODE_TICK, command: cmd_e'($urandom_range(3)),
                          now_sec: TIME_W'(now), at_start: at_start});
    beats_queued++;
  endfunction

  // Queue one command beat; time and switch fields are randomized
  function automatic void add_cmd(cmd_e c);
    pending_q.push_back('{mode: MODE_CMD, command: c,
                          now_sec: TIME_W'($urandom_range(TIME_MAX)),
                          at_start: 1'($urandom_range(1))});
    beats_queued++;
  endfunction

  function automatic bit quiet_window();
    return beats_sent >= CALM_FROM && beats_sent < CALM_TO;
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Write one schedule register and mirror it in the shadow copy
  task automatic set_reg(cfg_idx_e idx, int value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_START: sched.start_time = data;
      CFG_STOP:  sched.stop_time  = data;
      CFG_NIGHT: sched.night_time = data;
      CFG_MOVE:  sched.move_time  = data;
      default: begin
        sched.moves_per_day = data[MPD_W-1:0];
        if (sched.moves_per_day == '0) sched.moves_per_day = MPD_W'(1);
      end
    endcase
  endtask

  task automatic set_schedule(int start_s, int stop_s, int night_s, int move_s, int mpd);
    set_reg(CFG_START, start_s);
    set_reg(CFG_STOP, stop_s);
    set_reg(CFG_NIGHT, night_s);
    set_reg(CFG_MOVE, move_s);
    set_reg(CFG_MPD, mpd);
  endtask

  // Wait until every queued beat has been accepted and answered
  task automatic settle();
    while (pending_q.size() != 0 || bus_busy || motor_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One compressed day: auto, return to start, then walk the clock to night
  task automatic run_day();
    int day_now;
    int night_end;
    int odds;
    int n;
    add_cmd(CMD_AUTO);
    repeat ($urandom_range(3)) add_tick($urandom_range(TIME_MAX), 1'b1);
    case ($urandom_range(3))
      0:       day_now = sched.start_time - $urandom_range(3, 1);
      1:       day_now = sched.start_time + $urandom_range(sched.stop_time - sched.start_time);
      2:       day_now = sched.stop_time + $urandom_range(3, 1);
      default: day_now = sched.start_time;
    endcase
    add_tick(day_now, 1'b0);
    night_end = sched.night_time + 3;
    odds      = $urandom_range(4, 2);
    n         = 0;
    while (day_now <= night_end && n < 300) begin
      if ($urandom_range(99) < 3) begin
        // stray beat anywhere in the field ranges
        if ($urandom_range(1)) add_cmd(cmd_e'($urandom_range(3)));
        else add_tick($urandom_range(TIME_MAX), 1'($urandom_range(1)));
      end else begin
        add_tick(day_now, 1'($urandom_range(9) == 0));
      end
      if ($urandom_range(odds, 1) == 1) day_now++;
      n++;
    end
  endtask

  // Input driver: load the next pending beat, hold it until accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      bus_busy     = 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        motor_exp_q.push_back(predict_beat(beat_on_bus));
        bus_busy = 1'b0;
        beats_sent++;
      end
      if (!bus_busy) begin
        if (pending_q.size() != 0 && (quiet_window() || $urandom_range(99) >= IDLE_PCT)) begin
          beat_on_bus     = pending_q.pop_front();
          bus_busy        = 1'b1;
          in_if.valid    <= 1'b1;
          in_if.mode     <= beat_on_bus.mode;
          in_if.command  <= beat_on_bus.command;
          in_if.now_sec  <= beat_on_bus.now_sec;
          in_if.at_start <= beat_on_bus.at_start;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Hold off the output once for a long stretch to back up the input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && beats_sent >= HOLD_AT_BEAT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    motor_out_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (motor_exp_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result beat %0d: valid=%0b cmd=%0d state=%0d",
                                  results_seen, out_if.drive_valid, out_if.drive_cmd,
                                  out_if.seq_state));
        end else begin
          want = motor_exp_q.pop_front();
          if (out_if.drive_valid !== want.drive_valid || out_if.drive_cmd !== want.drive_cmd ||
              out_if.seq_state !== want.seq_state) begin
            flag_mismatch($sformatf(
              "result beat %0d: exp valid=%0b cmd=%0d state=%0d, got valid=%0b cmd=%0d state=%0d",
              results_seen, want.drive_valid, want.drive_cmd, want.seq_state,
              out_if.drive_valid, out_if.drive_cmd, out_if.seq_state));
          end
        end
        results_seen++;
      end
      out_if.ready <= (hold_left == 0) && (quiet_window() || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog
  initial begin
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus sequence
  initial begin : stimulus
    int day_cnt;
    int base_cnt;
    int t0;
    int span_s;
    int mpd_n;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_START;
    cfg_data_i     = '0;
    in_if.valid    = 1'b0;
    in_if.mode     = MODE_TICK;
    in_if.command  = CMD_STOP;
    in_if.now_sec  = '0;
    in_if.at_start = 1'b1;
    out_if.ready   = 1'b0;
    bus_busy       = 1'b0;
    beats_queued   = 0;
    beats_sent     = 0;
    results_seen   = 0;
    mismatches     = 0;
    sched          = '{start_time: START_RST, stop_time: STOP_RST, night_time: NIGHT_RST,
                       move_time: MOVE_RST, moves_per_day: MPD_RST};
    seq_q          = ST_MANUAL;
    presc_q        = '0;
    secs_q         = '0;
    period_q       = '0;
    on_secs_q      = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default schedule: every command, every state but pausing, field extremes
    add_tick(0, 1'b0);
    add_tick(TIME_MAX, 1'b1);
    add_cmd(CMD_FORWARD);
    add_cmd(CMD_BACK);
    add_cmd(CMD_STOP);
    add_cmd(CMD_AUTO);
    add_tick(40000, 1'b1);
    add_tick(100, 1'b0);
    add_tick(32399, 1'b0);
    add_tick(32400, 1'b0);
    add_tick(64800, 1'b0);
    add_tick(71999, 1'b0);
    add_tick(TIME_MAX, 1'b0);
    add_tick(48600, 1'b0);
    add_tick(DAY_LAST, 1'b1);
    add_tick(DAY_LAST, 1'b1);
    add_tick(DAY_LAST, 1'b0);
    add_cmd(CMD_AUTO);
    add_tick(64800, 1'b0);
    add_cmd(CMD_STOP);
    settle();

    // Zero span, widest move time, written zero moves count
    set_schedule(1000, 1000, 1001, TIME_MAX, 0);
    add_cmd(CMD_AUTO);
    add_tick(1000, 1'b0);
    repeat (12) add_tick(999, 1'b0);
    add_tick(1000, 1'b0);
    add_tick(1001, 1'b1);
    settle();

    // Stop before start: negative period, then pause that never ends
    set_schedule(100, 40, DAY_LAST, 0, 3);
    add_cmd(CMD_AUTO);
    add_tick(99, 1'b0);
    add_tick(100, 1'b0);
    settle();
    set_reg(CFG_STOP, 200);
    repeat (14) add_tick(150, 1'b0);
    add_tick(200, 1'b0);
    add_tick(DAY_LAST, 1'b0);
    settle();

    // Whole-day span with the largest moves count, then a written 0x10000
    set_schedule(0, DAY_LAST, DAY_LAST, DAY_LAST, 65535);
    add_cmd(CMD_AUTO);
    add_tick(0, 1'b0);
    repeat (4) add_tick(40000, 1'b0);
    settle();
    set_reg(CFG_MPD, 'h10000);
    add_cmd(CMD_AUTO);
    add_tick(43200, 1'b0);
    add_tick(DAY_LAST, 1'b0);

    // Random compressed days under short random schedules
    base_cnt = beats_queued;
    day_cnt  = 0;
    while (beats_queued - base_cnt < RANDOM_BEATS) begin
      if (day_cnt % 2 == 0) begin
        settle();
        t0     = $urandom_range(86000, 10);
        span_s = $urandom_range(30, 4);
        mpd_n  = $urandom_range(8, 1);
        set_schedule(t0, t0 + span_s, t0 + span_s + $urandom_range(10, 1),
                     $urandom_range(3 * mpd_n), mpd_n);
      end
      run_day();
      day_cnt++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && motor_exp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/dsms_pkg.sv
sv/dsms_if.sv
sv/dsms_cfg.sv
sv/dsms_div.sv
sv/daily_schedule_motor_sequencer_core.sv
tb/sv/tb_daily_schedule_motor_sequencer_core.sv
